/* src/pkpad_pkg.sv */
// ---------------------------------------------------------------------------
// pkpad_pkg: shared types and constants of the PKCS#1 v1.5 signature padder
// Register layout, byte constants of the encoding, and the records that
// pass between the front stage and the result stage.
// ---------------------------------------------------------------------------
package pkpad_pkg;

	localparam int MAX_DIGEST_BYTES  = 64;
	localparam int MAX_ENCODED_BYTES = 512;
	localparam int MAX_OID_BYTES     = 9;

	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;

	// Register reset values
	localparam logic        RST_CHECK_MODE      = 1'b0;
	localparam logic [9:0]  RST_ENCODED_LENGTH  = 10'd256;
	localparam logic [6:0]  RST_DIGEST_LENGTH   = 7'd32;
	localparam logic [3:0]  RST_OID_LENGTH      = 4'd0;
	localparam logic [63:0] RST_OID_FIRST_BYTES = 64'd0;
	localparam logic [7:0]  RST_OID_NINTH_BYTE  = 8'd0;

	// Encoding constants
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] BYTE_BLOCK    = 8'h01;
	localparam logic [7:0] BYTE_PAD      = 8'hFF;
	localparam logic [7:0] TAG_SEQUENCE  = 8'h30;
	localparam logic [7:0] TAG_OID       = 8'h06;
	localparam logic [7:0] TAG_NULL      = 8'h05;
	localparam logic [7:0] TAG_OCTETS    = 8'h04;
	localparam logic [7:0] OUTER_SEQ_ADD = 8'h08;
	localparam logic [7:0] ALG_SEQ_ADD   = 8'h04;
	// Fixed bytes: 00 01 ... 00 30 len 30 len 06 len ... 05 00 04 len
	localparam int FIXED_BYTES  = 13;
	// Bytes from the separator to the first OID content byte
	localparam int HDR_TO_OID   = 7;
	// Bytes that follow the padding run apart from OID and digest
	localparam int TAIL_FIXED   = 11;

	typedef enum logic { ACT_LOAD = 1'b0, ACT_EMIT = 1'b1 } action_t;

	typedef struct packed {
		logic        check_mode;
		logic [9:0]  encoded_length;
		logic [6:0]  digest_length;
		logic [3:0]  oid_length;
		logic [63:0] oid_first_bytes;
		logic [7:0]  oid_ninth_byte;
	} cfg_t;

	// What the front stage decides for one emitted position
	typedef struct packed {
		logic       dig_sel;
		logic [7:0] const_byte;
		logic       last;
		logic       err;
		logic [7:0] data;
		logic       check;
	} front_t;

	typedef struct packed {
		logic [7:0] encoded_byte;
		logic       last_byte;
		logic       mismatch;
		logic       size_error;
	} res_t;

	function automatic logic [7:0] oid_byte(input logic [63:0] first, input logic [7:0] ninth,
			input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0: b = first[63:56];
			4'd1: b = first[55:48];
			4'd2: b = first[47:40];
			4'd3: b = first[39:32];
			4'd4: b = first[31:24];
			4'd5: b = first[23:16];
			4'd6: b = first[15:8];
			4'd7: b = first[7:0];
			default: b = ninth;
		endcase
		return b;
	endfunction

endpackage

/* src/pkpad_in_if.sv */
// ---------------------------------------------------------------------------
// pkpad_in_if: input item channel
// Valid/ready channel carrying one load or emit command.
// ---------------------------------------------------------------------------
interface pkpad_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, action, data_byte, input ready);
	modport sink (input valid, action, data_byte, output ready);
endinterface

/* src/pkpad_out_if.sv */
// ---------------------------------------------------------------------------
// pkpad_out_if: result channel
// Valid/ready channel carrying one encoded byte with its flags.
// ---------------------------------------------------------------------------
interface pkpad_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] encoded_byte;
	logic       last_byte;
	logic       mismatch;
	logic       size_error;

	modport source (output valid, encoded_byte, last_byte, mismatch, size_error, input ready);
	modport sink (input valid, encoded_byte, last_byte, mismatch, size_error, output ready);
endinterface

/* src/pkpad_ram.sv */
// ---------------------------------------------------------------------------
// pkpad_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module pkpad_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/pkpad_cfg.sv */
// ---------------------------------------------------------------------------
// pkpad_cfg: APB configuration registers
// Holds mode, lengths and OID bytes; registers sit at 8-byte strides.
// ---------------------------------------------------------------------------
module pkpad_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pkpad_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [pkpad_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [pkpad_pkg::APB_DATA_W-1:0]  prdata,
	output logic                              pready,
	output pkpad_pkg::cfg_t                   cfg
);

	typedef enum logic [2:0] {
		REG_CHECK_MODE      = 3'd0,
		REG_ENCODED_LENGTH  = 3'd1,
		REG_DIGEST_LENGTH   = 3'd2,
		REG_OID_LENGTH      = 3'd3,
		REG_OID_FIRST_BYTES = 3'd4,
		REG_OID_NINTH_BYTE  = 3'd5
	} reg_idx_t;

	pkpad_pkg::cfg_t cfg_q;
	logic            wr_en;
	reg_idx_t        idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[5:3]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_mode      <= pkpad_pkg::RST_CHECK_MODE;
			cfg_q.encoded_length  <= pkpad_pkg::RST_ENCODED_LENGTH;
			cfg_q.digest_length   <= pkpad_pkg::RST_DIGEST_LENGTH;
			cfg_q.oid_length      <= pkpad_pkg::RST_OID_LENGTH;
			cfg_q.oid_first_bytes <= pkpad_pkg::RST_OID_FIRST_BYTES;
			cfg_q.oid_ninth_byte  <= pkpad_pkg::RST_OID_NINTH_BYTE;
		end else if (wr_en) begin
			case (idx)
				REG_CHECK_MODE:      cfg_q.check_mode      <= pwdata[0];
				REG_ENCODED_LENGTH:  cfg_q.encoded_length  <= pwdata[9:0];
				REG_DIGEST_LENGTH:   cfg_q.digest_length   <= pwdata[6:0];
				REG_OID_LENGTH:      cfg_q.oid_length      <= pwdata[3:0];
				REG_OID_FIRST_BYTES: cfg_q.oid_first_bytes <= pwdata;
				REG_OID_NINTH_BYTE:  cfg_q.oid_ninth_byte  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CHECK_MODE:      prdata = {63'd0, cfg_q.check_mode};
			REG_ENCODED_LENGTH:  prdata = {54'd0, cfg_q.encoded_length};
			REG_DIGEST_LENGTH:   prdata = {57'd0, cfg_q.digest_length};
			REG_OID_LENGTH:      prdata = {60'd0, cfg_q.oid_length};
			REG_OID_FIRST_BYTES: prdata = cfg_q.oid_first_bytes;
			REG_OID_NINTH_BYTE:  prdata = {56'd0, cfg_q.oid_ninth_byte};
			default:             prdata = '0;
		endcase
	end

endmodule

/* src/pkpad_front.sv */
// ---------------------------------------------------------------------------
// pkpad_front: position tracking and byte selection
// Keeps the emit position and load index, drives the digest store ports
// and classifies each emitted position.
// ---------------------------------------------------------------------------
module pkpad_front #(
	parameter int MAX_DIGEST_BYTES  = pkpad_pkg::MAX_DIGEST_BYTES,
	parameter int MAX_ENCODED_BYTES = pkpad_pkg::MAX_ENCODED_BYTES,
	parameter int MAX_OID_BYTES     = pkpad_pkg::MAX_OID_BYTES,
	localparam int AW = $clog2(MAX_DIGEST_BYTES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pkpad_pkg::cfg_t      cfg,
	input  logic                 accept,
	input  logic                 action,
	input  logic [7:0]           data_byte,
	output logic                 ram_we,
	output logic [AW-1:0]        ram_waddr,
	output logic [AW-1:0]        ram_raddr,
	output pkpad_pkg::front_t    front
);

	localparam int PW = $clog2(MAX_ENCODED_BYTES);
	localparam int CW = $clog2(MAX_ENCODED_BYTES + 1) + 1;

	logic [PW-1:0] emit_pos_q;
	logic [AW-1:0] load_idx_q;

	logic [CW-1:0] len_l, len_d, len_o, need, pos, hs, p, q, dstart;
	logic          err, last, is_emit;

	assign is_emit = (action == pkpad_pkg::ACT_EMIT);

	always_comb begin
		// Saturate the lengths
		len_l = (CW'(cfg.encoded_length) > CW'(MAX_ENCODED_BYTES)) ?
			CW'(MAX_ENCODED_BYTES) : CW'(cfg.encoded_length);
		len_d = (CW'(cfg.digest_length) > CW'(MAX_DIGEST_BYTES)) ?
			CW'(MAX_DIGEST_BYTES) : CW'(cfg.digest_length);
		len_o = (CW'(cfg.oid_length) > CW'(MAX_OID_BYTES)) ?
			CW'(MAX_OID_BYTES) : CW'(cfg.oid_length);
		need  = CW'(pkpad_pkg::FIXED_BYTES) + len_o + len_d;
		err   = len_l < need;

		// Restart if the length was lowered under the current position
		pos    = (CW'(emit_pos_q) >= len_l) ? '0 : CW'(emit_pos_q);
		last   = (len_l != '0) && (pos == len_l - CW'(1));
		hs     = len_l - CW'(pkpad_pkg::TAIL_FIXED) - len_o - len_d;
		p      = pos - hs;
		q      = p - CW'(pkpad_pkg::HDR_TO_OID) - len_o;
		dstart = len_l - len_d;

		front.dig_sel    = 1'b0;
		front.const_byte = pkpad_pkg::BYTE_ZERO;
		front.last       = last;
		front.err        = err;
		front.data       = data_byte;
		front.check      = cfg.check_mode;

		if (err) begin
			front.const_byte = pkpad_pkg::BYTE_ZERO;
		end else if (pos == CW'(0)) begin
			front.const_byte = pkpad_pkg::BYTE_ZERO;
		end else if (pos == CW'(1)) begin
			front.const_byte = pkpad_pkg::BYTE_BLOCK;
		end else if (pos < hs) begin
			front.const_byte = pkpad_pkg::BYTE_PAD;
		end else if (p < CW'(pkpad_pkg::HDR_TO_OID)) begin
			case (p[2:0])
				3'd0: front.const_byte = pkpad_pkg::BYTE_ZERO;
				3'd1: front.const_byte = pkpad_pkg::TAG_SEQUENCE;
				3'd2: front.const_byte = pkpad_pkg::OUTER_SEQ_ADD + 8'(len_o) + 8'(len_d);
				3'd3: front.const_byte = pkpad_pkg::TAG_SEQUENCE;
				3'd4: front.const_byte = pkpad_pkg::ALG_SEQ_ADD + 8'(len_o);
				3'd5: front.const_byte = pkpad_pkg::TAG_OID;
				3'd6: front.const_byte = 8'(len_o);
				default: front.const_byte = pkpad_pkg::BYTE_ZERO;
			endcase
		end else if (p < CW'(pkpad_pkg::HDR_TO_OID) + len_o) begin
			front.const_byte = pkpad_pkg::oid_byte(cfg.oid_first_bytes, cfg.oid_ninth_byte,
				4'(p - CW'(pkpad_pkg::HDR_TO_OID)));
		end else if (pos >= dstart) begin
			front.dig_sel = 1'b1;
		end else begin
			case (q[1:0])
				2'd0: front.const_byte = pkpad_pkg::TAG_NULL;
				2'd1: front.const_byte = pkpad_pkg::BYTE_ZERO;
				2'd2: front.const_byte = pkpad_pkg::TAG_OCTETS;
				2'd3: front.const_byte = 8'(len_d);
				default: front.const_byte = pkpad_pkg::BYTE_ZERO;
			endcase
		end
	end

	assign ram_we    = accept && !is_emit;
	assign ram_waddr = load_idx_q;
	assign ram_raddr = AW'(pos - dstart);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_pos_q <= '0;
			load_idx_q <= '0;
		end else if (accept) begin
			if (!is_emit) begin
				// Wrap after the last store entry
				load_idx_q <= (load_idx_q == AW'(MAX_DIGEST_BYTES - 1)) ?
					'0 : load_idx_q + AW'(1);
			end else if (last) begin
				emit_pos_q <= '0;
				load_idx_q <= '0;
			end else begin
				emit_pos_q <= PW'(pos + CW'(1));
			end
		end
	end

endmodule

/* src/pkpad_back.sv */
// ---------------------------------------------------------------------------
// pkpad_back: digest merge, compare and output register
// Picks the stored digest byte or the fixed byte, tracks the sticky
// mismatch and holds the result until it is taken.
// ---------------------------------------------------------------------------
module pkpad_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              emit_in,
	input  pkpad_pkg::front_t front,
	input  logic [7:0]        ram_rdata,
	input  logic              out_ready,
	output logic              take,
	output logic              out_valid,
	output pkpad_pkg::res_t   res
);

	pkpad_pkg::front_t front_s1;
	logic              valid_s1;
	pkpad_pkg::res_t   res_s2;
	logic              valid_s2;
	logic              mismatch_seen_q;

	logic              s2_en;
	logic [7:0]        byte_c;
	logic              seen_c;
	pkpad_pkg::res_t   res_c;

	assign s2_en = !valid_s2 || out_ready;
	assign take  = !valid_s1 || s2_en;

	always_comb begin
		byte_c = front_s1.dig_sel ? ram_rdata : front_s1.const_byte;
		seen_c = mismatch_seen_q ||
			(front_s1.check && !front_s1.err && (byte_c != front_s1.data));
		res_c.encoded_byte = byte_c;
		res_c.last_byte    = front_s1.last;
		res_c.mismatch     = front_s1.check && seen_c;
		res_c.size_error   = front_s1.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
			mismatch_seen_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= emit_in;
			end
			if (s2_en) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					mismatch_seen_q <= front_s1.last ? 1'b0 : seen_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			front_s1 <= front;
		end
		if (s2_en && valid_s1) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid = valid_s2;
	assign res       = res_s2;

endmodule

/* src/pkcs1_v15_signature_padder.sv */
// ---------------------------------------------------------------------------
// pkcs1_v15_signature_padder: EMSA-PKCS1-v1_5 encoder and checker
// Streams 00 01 FF..FF 00 DigestInfo one byte per emit command, with an
// optional byte-by-byte compare against received data.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Payload
//  items    in   valid/ready    action, data_byte
//  results  out  valid/ready    encoded_byte, last_byte, mismatch, size_error
//  apb      in   psel/penable   paddr, pwdata -> prdata (pready tied high)
//
//  One item per cycle sustained while results are taken; an emit transfer
//  shows its result after the front register, then the output register. The
//  digest store's registered read port lines up with the front register.
//  A load transfer writes the digest store and yields no result.
//  Reset clears positions, valid bits and the mismatch flag; the digest
//  store holds garbage until loaded and needs no clearing pass.
//  A stall on results holds the output register; items stay accepted
//  as long as the front register can move forward.
//
module pkcs1_v15_signature_padder #(
	parameter int MAX_DIGEST_BYTES  = pkpad_pkg::MAX_DIGEST_BYTES,
	parameter int MAX_ENCODED_BYTES = pkpad_pkg::MAX_ENCODED_BYTES,
	parameter int MAX_OID_BYTES     = pkpad_pkg::MAX_OID_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	pkpad_in_if.sink                         items,
	pkpad_out_if.source                      results,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pkpad_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [pkpad_pkg::APB_DATA_W-1:0] pwdata,
	output logic [pkpad_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready
);

	localparam int AW = $clog2(MAX_DIGEST_BYTES);

	pkpad_pkg::cfg_t   cfg;
	pkpad_pkg::front_t front;
	pkpad_pkg::res_t   res;

	logic          take;
	logic          accept;
	logic          emit_acc;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic          out_valid;

	// Take a transfer whenever the front register can advance
	assign items.ready = take;
	assign accept      = items.valid && take;
	assign emit_acc    = accept && (items.action == pkpad_pkg::ACT_EMIT);

	pkpad_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Position counter, load index and per-position byte choice
	pkpad_front #(
		.MAX_DIGEST_BYTES  (MAX_DIGEST_BYTES),
		.MAX_ENCODED_BYTES (MAX_ENCODED_BYTES),
		.MAX_OID_BYTES     (MAX_OID_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.action    (items.action),
		.data_byte (items.data_byte),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr),
		.front     (front)
	);

	// Digest store; read data lines up with the front register
	pkpad_ram #(
		.WIDTH (8),
		.DEPTH (MAX_DIGEST_BYTES)
	) u_digest_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (items.data_byte),
		.re    (accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Merge digest byte, compare, hold the result
	pkpad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit_in   (emit_acc),
		.front     (front),
		.ram_rdata (ram_rdata),
		.out_ready (results.ready),
		.take      (take),
		.out_valid (out_valid),
		.res       (res)
	);

	assign results.valid        = out_valid;
	assign results.encoded_byte = res.encoded_byte;
	assign results.last_byte    = res.last_byte;
	assign results.mismatch     = res.mismatch;
	assign results.size_error   = res.size_error;

endmodule

/* src/pkpad_checker.sv */
// ---------------------------------------------------------------------------
// pkpad_checker: port-level assertions for the signature padder
// Watches the result channel over time; attached by bind.
// ---------------------------------------------------------------------------
module pkpad_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] encoded_byte,
	input logic       last_byte,
	input logic       mismatch,
	input logic       size_error
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(encoded_byte) && $stable(mismatch))
		else $error("result changed while stalled");

	// No result while in reset
	assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	// A size error always carries a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && size_error |-> encoded_byte == 8'h00)
		else $error("size error with nonzero byte");

	// Mismatch stays up until the end of the message
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && mismatch && !last_byte |=>
		!(res_valid && res_ready) || mismatch)
		else $error("mismatch dropped inside a message");

endmodule

bind pkcs1_v15_signature_padder pkpad_checker u_pkpad_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (results.valid),
	.res_ready    (results.ready),
	.encoded_byte (results.encoded_byte),
	.last_byte    (results.last_byte),
	.mismatch     (results.mismatch),
	.size_error   (results.size_error)
);

/* verif/pkcs1_v15_signature_padder_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pkcs1_v15_signature_padder_tb: self-checking bench for the signature padder
// Drives load and emit commands through the item channel and programs the
// registers over APB while the block is idle. A shadow encoder predicts every
// encoded byte with its flags, and each result transfer is checked field by
// field in order. A short directed table opens the run; random sessions of
// well-formed messages with some noise follow under three pacing regimes.
// ---------------------------------------------------------------------------
module pkcs1_v15_signature_padder_tb;
	import pkpad_pkg::*;

	// Cycles with no transfer of any kind before the run is declared hung
	localparam int QUIET_LIMIT  = 5000;
	// An emit passes the front and output registers; leave margin before touching registers
	localparam int DRAIN_CYCLES = 4;
	// One register every eight bytes, since the OID word is 64 bits wide
	localparam int REG_STRIDE   = 8;

	typedef enum int {
		REG_CHECK_MODE,
		REG_ENCODED_LENGTH,
		REG_DIGEST_LENGTH,
		REG_OID_LENGTH,
		REG_OID_FIRST_BYTES,
		REG_OID_NINTH_BYTE
	} reg_e;

	// Rows of the directed table
	typedef enum int { STEP_CFG, STEP_LOAD, STEP_EMIT, STEP_EMIT_MATCH } step_kind_e;

	typedef struct {
		step_kind_e  kind;
		int          sel;
		logic [63:0] value;
		int          reps;
		bit          typed;
		res_t        want;
	} step_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	pkpad_in_if  item_ch ();
	pkpad_out_if result_ch ();

	pkcs1_v15_signature_padder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the block: register copy, digest store, positions, sticky flag
	cfg_t       shadow;
	logic [7:0] digest_mem [MAX_DIGEST_BYTES];
	logic [5:0] load_ptr;
	int         pad_pos;
	bit         mis_seen;

	// Encoded bytes predicted but not yet seen on the result channel
	res_t owed_bytes[$];

	step_t plan[$];

	int send_gap_pct;
	int recv_stall_pct;
	int items_sent;
	int loads_sent;
	int bytes_checked;
	int messages_done;
	int mismatch_flags;
	int size_errors;
	int cfg_writes;
	int fault_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow encoder
	// ------------------------------------------------------------------
	function automatic int clamp(input int v, input int hi);
		return (v > hi) ? hi : v;
	endfunction

	// Saturate the length registers the way the block does
	function automatic void eff_dims(output int L, output int D, output int O);
		L = clamp(int'(shadow.encoded_length), MAX_ENCODED_BYTES);
		D = clamp(int'(shadow.digest_length), MAX_DIGEST_BYTES);
		O = clamp(int'(shadow.oid_length), MAX_OID_BYTES);
	endfunction

	function automatic logic [7:0] oid_at(input int i);
		if (i < 8)
			return shadow.oid_first_bytes[63 - 8 * i -: 8];
		return shadow.oid_ninth_byte;
	endfunction

	// Byte at pos of 00 01 FF..FF 00 30 n 30 n 06 O oid 05 00 04 D digest;
	// only called with a legal size
	function automatic logic [7:0] pad_byte_at(input int pos, input int L, input int D,
			input int O);
		int ps;
		int p;
		int q;
		ps = L - 13 - O - D;
		if (pos == 0)
			return 8'h00;
		if (pos == 1)
			return 8'h01;
		if (pos < 2 + ps)
			return 8'hFF;
		p = pos - 2 - ps;
		case (p)
			0: return 8'h00;
			1: return 8'h30;
			2: return 8'(8 + O + D);
			3: return 8'h30;
			4: return 8'(4 + O);
			5: return 8'h06;
			6: return 8'(O);
			default: ;
		endcase
		if (p < 7 + O)
			return oid_at(p - 7);
		q = p - 7 - O;
		case (q)
			0: return 8'h05;
			1: return 8'h00;
			2: return 8'h04;
			3: return 8'(D);
			default: ;
		endcase
		q = q - 4;
		if (q < D)
			return digest_mem[q];
		return 8'h00;
	endfunction

	function automatic void store_digest_byte(input logic [7:0] d);
		digest_mem[load_ptr] = d;
		load_ptr = load_ptr + 6'd1;
	endfunction

	// Advance the shadow by one emit and return the byte with its flags
	function automatic res_t encode_emit(input logic [7:0] rx);
		int L;
		int D;
		int O;
		bit err;
		bit last;
		logic [7:0] b;
		res_t r;
		eff_dims(L, D, O);
		err = L < 13 + O + D;
		// A length lowered under the current position restarts the message
		if (pad_pos >= L)
			pad_pos = 0;
		b = err ? 8'h00 : pad_byte_at(pad_pos, L, D, O);
		last = (L != 0) && (pad_pos == L - 1);
		if (shadow.check_mode && !err && b != rx)
			mis_seen = 1'b1;
		r.encoded_byte = b;
		r.last_byte = last;
		r.mismatch = shadow.check_mode ? mis_seen : 1'b0;
		r.size_error = err;
		if (last) begin
			pad_pos = 0;
			load_ptr = '0;
			mis_seen = 1'b0;
		end else begin
			pad_pos++;
		end
		return r;
	endfunction

	// Byte the next emit will produce, without moving the shadow
	function automatic logic [7:0] upcoming_byte();
		int L;
		int D;
		int O;
		eff_dims(L, D, O);
		if (L < 13 + O + D)
			return 8'h00;
		return pad_byte_at((pad_pos >= L) ? 0 : pad_pos, L, D, O);
	endfunction

	function automatic res_t outcome(input logic [7:0] b, input bit last, input bit mis,
			input bit err);
		res_t r;
		r.encoded_byte = b;
		r.last_byte = last;
		r.mismatch = mis;
		r.size_error = err;
		return r;
	endfunction

	function automatic step_t plan_step(input step_kind_e kind, input int sel,
			input logic [63:0] value, input int reps, input bit typed = 1'b0,
			input res_t want = '0);
		step_t s;
		s.kind = kind;
		s.sel = sel;
		s.value = value;
		s.reps = reps;
		s.typed = typed;
		s.want = want;
		return s;
	endfunction

	// Mostly a full digest per message; now and then a short or long burst
	function automatic int message_loads(input int D);
		return ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 70)) : D;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one item, hold it until the transfer, then predict its result or store the load.
	// Called at a rising edge; returns at the edge of the transfer with
	// valid still high so back-to-back items flow without a bubble.
	task automatic send(input action_t act, input logic [7:0] d, input bit typed = 1'b0,
			input res_t want = '0);
		res_t r;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.data_byte <= d;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		items_sent++;
		if (act == ACT_EMIT) begin
			r = encode_emit(d);
			owed_bytes.push_back(typed ? want : r);
		end else begin
			store_digest_byte(d);
			loads_sent++;
		end
	endtask

	// Drop valid, drain every owed byte, then let a trailing load settle
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (owed_bytes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Setup phase, access phase, then idle with psel low so the next write
	// never lowers and raises psel in the same step
	task automatic write_reg(input reg_e idx, input logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(int'(idx) * REG_STRIDE);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_CHECK_MODE:      shadow.check_mode = v[0];
			REG_ENCODED_LENGTH:  shadow.encoded_length = v[9:0];
			REG_DIGEST_LENGTH:   shadow.digest_length = v[6:0];
			REG_OID_LENGTH:      shadow.oid_length = v[3:0];
			REG_OID_FIRST_BYTES: shadow.oid_first_bytes = v;
			REG_OID_NINTH_BYTE:  shadow.oid_ninth_byte = v[7:0];
			default: ;
		endcase
		cfg_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// One random register setting followed by a stream of messages: load
	// the digest, then emit every position with the right byte echoed back.
	// Noise items and corrupted echoes break the pattern now and then.
	// A session may end mid-message, so the next setting can land with the
	// position past the new end.
	task automatic run_session(input int budget, input bit wide);
		int D;
		int O;
		int L;
		int De;
		int Oe;
		int sent;
		int loads_due;
		bit check;
		logic [63:0] oid;
		logic [7:0] d;
		wait_idle();
		O = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 15))
			: int'($urandom_range(0, 9));
		case ($urandom_range(0, 11))
			0: D = 0;
			1: D = MAX_DIGEST_BYTES;
			2: D = $urandom_range(65, 127);
			default: D = $urandom_range(1, 40);
		endcase
		Oe = clamp(O, MAX_OID_BYTES);
		De = clamp(D, MAX_DIGEST_BYTES);
		if (wide) begin
			L = $urandom_range(0, 1) ? MAX_ENCODED_BYTES : int'($urandom_range(513, 1023));
			budget = MAX_ENCODED_BYTES + De + 40;
		end else if ($urandom_range(0, 9) == 0) begin
			// too short for the DigestInfo
			L = $urandom_range(0, 12 + Oe + De);
		end else begin
			L = 13 + Oe + De + $urandom_range(0, 24);
		end
		case ($urandom_range(0, 5))
			0: oid = '0;
			1: oid = '1;
			default: oid = {$urandom, $urandom};
		endcase
		check = ($urandom_range(0, 2) != 0);
		write_reg(REG_CHECK_MODE, 64'(check));
		write_reg(REG_ENCODED_LENGTH, 64'(L));
		write_reg(REG_DIGEST_LENGTH, 64'(D));
		write_reg(REG_OID_LENGTH, 64'(O));
		write_reg(REG_OID_FIRST_BYTES, oid);
		write_reg(REG_OID_NINTH_BYTE, 64'($urandom_range(0, 255)));

		loads_due = (pad_pos == 0) ? message_loads(De) : 0;
		for (sent = 0; sent < budget; sent++) begin
			if ($urandom_range(0, 99) < 6) begin
				send(action_t'($urandom_range(0, 1)), 8'($urandom));
			end else if (loads_due > 0) begin
				send(ACT_LOAD, 8'($urandom));
				loads_due--;
			end else begin
				d = upcoming_byte();
				if (check && $urandom_range(0, 99) < 4)
					d = d ^ 8'($urandom_range(1, 255));
				send(ACT_EMIT, d);
				if (pad_pos == 0)
					loads_due = message_loads(De);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	task automatic check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			fault_count++;
			$display("%0t ns: %s expected %02h, got %02h", $time, field, want, got);
		end
	endtask

	// Stall the receiver at random and match each result transfer against
	// the oldest owed byte. Values read here are those before the edge.
	always @(posedge clk) begin : result_monitor
		res_t want;
		result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (owed_bytes.size() == 0) begin
				fault_count++;
				$display("%0t ns: result with nothing owed, expected none, got byte %02h",
					$time, result_ch.encoded_byte);
			end else begin
				want = owed_bytes.pop_front();
				check_field("encoded_byte", want.encoded_byte, result_ch.encoded_byte);
				check_field("last_byte", 8'(want.last_byte), 8'(result_ch.last_byte));
				check_field("mismatch", 8'(want.mismatch), 8'(result_ch.mismatch));
				check_field("size_error", 8'(want.size_error), 8'(result_ch.size_error));
				bytes_checked++;
				if (want.last_byte)
					messages_done++;
				if (want.mismatch)
					mismatch_flags++;
				if (want.size_error)
					size_errors++;
			end
		end
	end

	// End the run if neither channel nor the register port moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
					|| (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t ns: no transfer for %0d cycles, %0d bytes still owed", $time,
			QUIET_LIMIT, owed_bytes.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		int phase;
		int i;
		int start;
		int target;

		item_ch.valid = 1'b0;
		item_ch.action = 1'b0;
		item_ch.data_byte = '0;
		result_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		items_sent = 0;
		loads_sent = 0;
		bytes_checked = 0;
		messages_done = 0;
		mismatch_flags = 0;
		size_errors = 0;
		cfg_writes = 0;
		fault_count = 0;

		shadow = {RST_CHECK_MODE, RST_ENCODED_LENGTH, RST_DIGEST_LENGTH, RST_OID_LENGTH,
			RST_OID_FIRST_BYTES, RST_OID_NINTH_BYTE};
		load_ptr = '0;
		pad_pos = 0;
		mis_seen = 1'b0;

		// Directed table. The store is filled before it runs, so the first
		// two emits still see the reset position and reset registers.
		plan.push_back(plan_step(STEP_EMIT, 0, 8'h00, 1, 1'b1, outcome(8'h00, 0, 0, 0)));
		plan.push_back(plan_step(STEP_EMIT, 0, 8'h5A, 1, 1'b1, outcome(8'h01, 0, 0, 0)));
		// Shortest legal message with an empty digest, checked mid-message
		plan.push_back(plan_step(STEP_CFG, REG_CHECK_MODE, 1, 1));
		plan.push_back(plan_step(STEP_CFG, REG_DIGEST_LENGTH, 0, 1));
		plan.push_back(plan_step(STEP_CFG, REG_OID_LENGTH, 0, 1));
		plan.push_back(plan_step(STEP_CFG, REG_ENCODED_LENGTH, 13, 1));
		plan.push_back(plan_step(STEP_EMIT_MATCH, 0, 0, 10));
		// Wrong echo on the last byte raises the flag right there
		plan.push_back(plan_step(STEP_EMIT, 0, 8'h77, 1, 1'b1, outcome(8'h00, 1, 1, 0)));
		// Three bytes too short: size error, nothing compared
		plan.push_back(plan_step(STEP_CFG, REG_ENCODED_LENGTH, 10, 1));
		plan.push_back(plan_step(STEP_EMIT, 0, 8'hFF, 1, 1'b1, outcome(8'h00, 0, 0, 1)));
		// Every length register above its limit saturates
		plan.push_back(plan_step(STEP_CFG, REG_ENCODED_LENGTH, 1023, 1));
		plan.push_back(plan_step(STEP_CFG, REG_DIGEST_LENGTH, 127, 1));
		plan.push_back(plan_step(STEP_CFG, REG_OID_LENGTH, 15, 1));
		plan.push_back(plan_step(STEP_CFG, REG_OID_FIRST_BYTES, '1, 1));
		plan.push_back(plan_step(STEP_CFG, REG_OID_NINTH_BYTE, 8'hFF, 1));
		plan.push_back(plan_step(STEP_EMIT, 0, 8'h01, 1, 1'b1, outcome(8'h01, 0, 0, 0)));
		plan.push_back(plan_step(STEP_EMIT, 0, 8'hFF, 1, 1'b1, outcome(8'hFF, 0, 0, 0)));
		// Length cut under the position: restart at 0, last still marked
		plan.push_back(plan_step(STEP_CFG, REG_ENCODED_LENGTH, 2, 1));
		plan.push_back(plan_step(STEP_EMIT, 0, 8'h00, 1, 1'b1, outcome(8'h00, 0, 0, 1)));
		plan.push_back(plan_step(STEP_EMIT, 0, 8'h00, 1, 1'b1, outcome(8'h00, 1, 0, 1)));
		// Generate mode with no padding run; wrong echoes must not flag
		plan.push_back(plan_step(STEP_CFG, REG_CHECK_MODE, 0, 1));
		plan.push_back(plan_step(STEP_CFG, REG_ENCODED_LENGTH, 20, 1));
		plan.push_back(plan_step(STEP_CFG, REG_DIGEST_LENGTH, 4, 1));
		plan.push_back(plan_step(STEP_CFG, REG_OID_LENGTH, 3, 1));
		plan.push_back(plan_step(STEP_LOAD, 0, 8'hFF, 1));
		plan.push_back(plan_step(STEP_LOAD, 0, 8'h00, 1));
		plan.push_back(plan_step(STEP_EMIT, 0, 8'h33, 6));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pacing per phase: sender-light/receiver-heavy, the reverse, then none
		for (phase = 0; phase < 3; phase++) begin
			send_gap_pct = (phase == 0) ? 11 : (phase == 1) ? 69 : 0;
			recv_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 11 : 0;
			if (phase == 0) begin
				// Fill the whole store once, wrapping the load pointer, so no
				// later digest read can hit an entry that was never written
				for (i = 0; i < MAX_DIGEST_BYTES; i++)
					send(ACT_LOAD, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));
				foreach (plan[k]) begin
					case (plan[k].kind)
						STEP_CFG: begin
							wait_idle();
							write_reg(reg_e'(plan[k].sel), plan[k].value);
						end
						STEP_LOAD:
							repeat (plan[k].reps) send(ACT_LOAD, plan[k].value[7:0]);
						STEP_EMIT:
							repeat (plan[k].reps)
								send(ACT_EMIT, plan[k].value[7:0], plan[k].typed,
									plan[k].want);
						STEP_EMIT_MATCH:
							repeat (plan[k].reps) send(ACT_EMIT, upcoming_byte());
						default: ;
					endcase
				end
			end
			start = items_sent;
			// One full-size message, run where nothing idles to keep it short
			if (phase == 2)
				run_session(0, 1'b1);
			target = (phase == 2) ? 450 : 400;
			while (items_sent - start < target)
				run_session($urandom_range(60, 140), 1'b0);
		end

		// Drain what is still owed, then keep watching for strays
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d items (%0d loads) and %0d encoded bytes over %0d messages",
			items_sent, loads_sent, bytes_checked, messages_done);
		$display("%0d register writes; %0d bytes flagged mismatch, %0d flagged size error",
			cfg_writes, mismatch_flags, size_errors);
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
